FILE: hw/rtl/gfrow_pkg.sv
// Shared types, constants and the GF(2^8) multiply for the row-operation lanes.
// No dependencies.
package gfrow_pkg;

    localparam int OCTET_W = 8;
    localparam int OCTETS  = 8;                  // octets carried in one word
    localparam int WORD_W  = OCTETS * OCTET_W;
    localparam int LANES   = 8;                  // active lanes, 1..OCTETS
    localparam int KIND_W  = 3;

    // Field polynomial 0x11D; the x^8 term is implied by the shift-out.
    localparam logic [OCTET_W-1:0] FIELD_POLY_LOW = 8'h1D;

    typedef enum logic [KIND_W-1:0] {
        KIND_SWAP   = 3'd0,
        KIND_MAC    = 3'd1,
        KIND_ADD    = 3'd2,
        KIND_SCALE  = 3'd3,
        KIND_BITACC = 3'd4
    } kind_t;

    typedef logic [OCTET_W-1:0] octet_t;

    // Per-item control broadcast to every lane.
    typedef struct packed {
        kind_t  kind;
        octet_t mult;
    } lane_ctrl_t;

    // Shift-and-add product modulo the field polynomial.
    function automatic octet_t gf_mul(input octet_t x, input octet_t y);
        octet_t acc;
        octet_t a;
        acc = '0;
        a   = x;
        for (int i = 0; i < OCTET_W; i++) begin
            if (y[i]) begin
                acc = acc ^ a;
            end
            a = {a[OCTET_W-2:0], 1'b0} ^ (a[OCTET_W-1] ? FIELD_POLY_LOW : '0);
        end
        return acc;
    endfunction

endpackage

FILE: hw/rtl/gf256_row_operation_lanes.sv
// Top level of the GF(2^8) row-operation unit: lane array plus output merge register.
// Depends on gfrow_pkg, gfrow_lane and gfrow_merge.
//
// Applies one chunk of a matrix row operation per word: eight destination octets
// and eight source octets are processed side by side by eight identical lanes.
// Kinds: swap (exchange the two words), multiply-accumulate (dest ^= u*src),
// add (dest ^= src), scale (dest = u*dest, unchanged when u < 2) and bit-masked
// accumulate (dest octet n ^= u where s_src_bits[n] is set). Unused kind codes
// pass both words through. Multiplication is in GF(2^8) modulo 0x11D. Octet 0 is
// the low byte of each word. s_last_chunk is carried to m_last unchanged.
// Throughput is one word per clock while m_ready is high. Each result is held in
// the merge stage's output register from the cycle after its word is taken; s_ready
// stays high while it is empty or being drained, so words stream back to back.
// Row addressing and looping over a row's chunks are up to the feeder.
module gf256_row_operation_lanes
    import gfrow_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [KIND_W-1:0]  s_kind,
    input  logic [WORD_W-1:0]  s_dest_word,
    input  logic [WORD_W-1:0]  s_src_word,
    input  logic [OCTETS-1:0]  s_src_bits,
    input  logic [OCTET_W-1:0] s_multiplier,
    input  logic               s_last_chunk,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_new_dest_word,
    output logic [WORD_W-1:0]  m_new_src_word,
    output logic               m_last
);

    lane_ctrl_t                    ctrl;
    logic [OCTETS-1:0][OCTET_W-1:0] dest_octets;
    logic [OCTETS-1:0][OCTET_W-1:0] src_octets;
    logic [OCTETS-1:0][OCTET_W-1:0] lane_dest;
    logic [OCTETS-1:0][OCTET_W-1:0] lane_src;

    // Same control to every lane; out-of-range kinds hit the lanes' default arm.
    assign ctrl.kind   = kind_t'(s_kind);
    assign ctrl.mult   = s_multiplier;
    assign dest_octets = s_dest_word;
    assign src_octets  = s_src_word;

    for (genvar g = 0; g < OCTETS; g++) begin : g_lane
        if (g < LANES) begin : g_active
            gfrow_lane u_lane (
                .ctrl           (ctrl),
                .dest_octet     (dest_octets[g]),
                .src_octet      (src_octets[g]),
                .sel_bit        (s_src_bits[g]),
                .new_dest_octet (lane_dest[g]),
                .new_src_octet  (lane_src[g])
            );
        end else begin : g_idle
            // octets beyond the active lanes pass through
            assign lane_dest[g] = dest_octets[g];
            assign lane_src[g]  = src_octets[g];
        end
    end

    gfrow_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .lane_dest     (lane_dest),
        .lane_src      (lane_src),
        .in_last       (s_last_chunk),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_dest_word (m_new_dest_word),
        .out_src_word  (m_new_src_word),
        .out_last      (m_last)
    );

endmodule

FILE: hw/rtl/gfrow_lane.sv
// One octet lane: applies the item's operation to a destination/source octet pair.
// Depends on gfrow_pkg.
module gfrow_lane
    import gfrow_pkg::*;
(
    input  lane_ctrl_t ctrl,
    input  octet_t     dest_octet,
    input  octet_t     src_octet,
    input  logic       sel_bit,
    output octet_t     new_dest_octet,
    output octet_t     new_src_octet
);

    always_comb begin
        new_dest_octet = dest_octet;
        new_src_octet  = src_octet;
        case (ctrl.kind)
            KIND_SWAP: begin
                new_dest_octet = src_octet;
                new_src_octet  = dest_octet;
            end
            KIND_MAC: begin
                new_dest_octet = dest_octet ^ gf_mul(ctrl.mult, src_octet);
            end
            KIND_ADD: begin
                new_dest_octet = dest_octet ^ src_octet;
            end
            KIND_SCALE: begin
                // u of 0 or 1 leaves dest alone
                if (ctrl.mult[OCTET_W-1:1] != '0) begin
                    new_dest_octet = gf_mul(ctrl.mult, dest_octet);
                end
            end
            KIND_BITACC: begin
                if (sel_bit) begin
                    new_dest_octet = dest_octet ^ ctrl.mult;
                end
            end
            default: begin
                new_dest_octet = dest_octet;
                new_src_octet  = src_octet;
            end
        endcase
    end

endmodule

FILE: hw/rtl/gfrow_merge.sv
// Merge stage: gathers lane octets into result words and holds them in the output register.
// Depends on gfrow_pkg.
module gfrow_merge
    import gfrow_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [OCTETS-1:0][OCTET_W-1:0] lane_dest,
    input  logic [OCTETS-1:0][OCTET_W-1:0] lane_src,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [WORD_W-1:0]            out_dest_word,
    output logic [WORD_W-1:0]            out_src_word,
    output logic                         out_last
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] dest_reg;
    logic [WORD_W-1:0] src_reg;
    logic              last_reg;
    logic              load;

    // Register frees up in the same cycle it is drained.
    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dest_reg <= lane_dest;
            src_reg  <= lane_src;
            last_reg <= in_last;
        end
    end

    assign out_valid     = valid_reg;
    assign out_dest_word = dest_reg;
    assign out_src_word  = src_reg;
    assign out_last      = last_reg;

endmodule

FILE: tb/gf256_row_operation_lanes_test.sv
// Self-checking bench for the GF(2^8) row-operation lanes: directed and random chunks.
// Depends on gfrow_pkg and gf256_row_operation_lanes; nothing else is read.
module gf256_row_operation_lanes_test
    import gfrow_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1530;
    localparam int IDLE_PCT     = 27;
    // Window, counted in words, during which neither side idles.
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 800;
    // Receiver hold-off: starts once this many results are in, lasts this many cycles.
    localparam int HOLD_AT      = 1000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_LIMIT  = 500;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [WORD_W-1:0]  dest;
        logic [WORD_W-1:0]  src;
        logic [OCTETS-1:0]  bits;
        logic [OCTET_W-1:0] mult;
        logic               last;
    } row_chunk_t;

    typedef struct {
        logic [WORD_W-1:0] new_dest;
        logic [WORD_W-1:0] new_src;
        logic              last;
    } row_result_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [KIND_W-1:0]  s_kind          = '0;
    logic [WORD_W-1:0]  s_dest_word     = '0;
    logic [WORD_W-1:0]  s_src_word      = '0;
    logic [OCTETS-1:0]  s_src_bits      = '0;
    logic [OCTET_W-1:0] s_multiplier    = '0;
    logic               s_last_chunk    = 1'b0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [WORD_W-1:0]  m_new_dest_word;
    logic [WORD_W-1:0]  m_new_src_word;
    logic               m_last;

    row_chunk_t  chunk_q[$];     // words still to be offered
    row_result_t row_result_q[$]; // predicted results, oldest first
    row_chunk_t  cur_chunk;       // word currently on the input port
    row_result_t want;

    int words_in  = 0;
    int words_out = 0;
    int errors    = 0;
    int hold_left = 0;
    logic hold_armed = 1'b1;
    int kind_count[0:(1<<KIND_W)-1] = '{default: 0};

    gf256_row_operation_lanes DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_dest_word     (s_dest_word),
        .s_src_word      (s_src_word),
        .s_src_bits      (s_src_bits),
        .s_multiplier    (s_multiplier),
        .s_last_chunk    (s_last_chunk),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_dest_word (m_new_dest_word),
        .m_new_src_word  (m_new_src_word),
        .m_last          (m_last)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Field product, MSB-first (Horner): double the running sum, then add a
    // when the multiplier bit is set. Doubling reduces by x^8 = 0x1D.
    function automatic octet_t gf_product(octet_t a, octet_t b);
        octet_t acc;
        acc = '0;
        for (int i = OCTET_W - 1; i >= 0; i--) begin
            acc = {acc[OCTET_W-2:0], 1'b0} ^ (acc[OCTET_W-1] ? FIELD_POLY_LOW : '0);
            if (b[i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    // Per-lane row operation. Lanes at or above LANES, and unused kinds,
    // leave both octets as they came in; only swap touches the source word.
    function automatic row_result_t apply_row_op(row_chunk_t c);
        row_result_t r;
        octet_t      d;
        octet_t      s;
        octet_t      o;
        r.new_dest = c.dest;
        r.new_src  = c.src;
        r.last     = c.last;
        for (int n = 0; n < LANES && n < OCTETS; n++) begin
            d = c.dest[n*OCTET_W +: OCTET_W];
            s = c.src[n*OCTET_W +: OCTET_W];
            o = d;
            case (c.kind)
                KIND_SWAP: begin
                    o = s;
                    r.new_src[n*OCTET_W +: OCTET_W] = d;
                end
                KIND_MAC:    o = d ^ gf_product(c.mult, s);
                KIND_ADD:    o = d ^ s;
                // u of 0 or 1 leaves dest alone
                KIND_SCALE:  if (c.mult >= 2) o = gf_product(c.mult, d);
                KIND_BITACC: if (c.bits[n]) o = d ^ c.mult;
                default:     o = d;
            endcase
            r.new_dest[n*OCTET_W +: OCTET_W] = o;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_chunk(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] dest,
                             input logic [WORD_W-1:0] src, input logic [OCTETS-1:0] bits,
                             input logic [OCTET_W-1:0] mult, input logic last);
        row_chunk_t c;
        c.kind = kind;
        c.dest = dest;
        c.src  = src;
        c.bits = bits;
        c.mult = mult;
        c.last = last;
        chunk_q.push_back(c);
    endtask

    // Mostly random octets, with all-zero and all-one octets mixed in.
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        for (int n = 0; n < OCTETS; n++) begin
            case ($urandom_range(7))
                0:       w[n*OCTET_W +: OCTET_W] = '0;
                1:       w[n*OCTET_W +: OCTET_W] = '1;
                default: ;
            endcase
        end
        return w;
    endfunction

    function automatic logic [OCTET_W-1:0] random_mult();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h02;
            3:       return 8'hFF;
            default: return OCTET_W'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued words, holds payload until accepted, and
    // records the prediction at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                row_result_q.push_back(apply_row_op(cur_chunk));
                words_in <= words_in + 1;
                kind_count[cur_chunk.kind] <= kind_count[cur_chunk.kind] + 1;
            end
            // Port is free to take a new word (or to go idle)
            if (!s_valid || s_ready) begin
                if (chunk_q.size() != 0 &&
                    ((words_in >= CALM_FROM && words_in < CALM_TO) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    cur_chunk = chunk_q.pop_front();
                    s_valid      <= 1'b1;
                    s_kind       <= cur_chunk.kind;
                    s_dest_word  <= cur_chunk.dest;
                    s_src_word   <= cur_chunk.src;
                    s_src_bits   <= cur_chunk.bits;
                    s_multiplier <= cur_chunk.mult;
                    s_last_chunk <= cur_chunk.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, none in the calm window, and a
    // forced hold-off while the sender keeps pushing.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (hold_left == 0) &&
                       ((words_out >= CALM_FROM && words_out < CALM_TO) ||
                        $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Hold-off counter, in cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && words_out >= HOLD_AT) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            words_out <= words_out + 1;
            if (row_result_q.size() == 0) begin
                $error("result word with no prediction pending: dest %h src %h last %b",
                       m_new_dest_word, m_new_src_word, m_last);
                errors++;
            end else begin
                want = row_result_q.pop_front();
                if (m_new_dest_word !== want.new_dest) begin
                    $error("new_dest_word: expected %h, got %h", want.new_dest, m_new_dest_word);
                    errors++;
                end
                if (m_new_src_word !== want.new_src) begin
                    $error("new_src_word: expected %h, got %h", want.new_src, m_new_src_word);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the word list, reset, wait for drain, report.
    // ------------------------------------------------------------------
    initial begin
        int   total;
        int   drain;
        logic [KIND_W-1:0] k;

        // Directed: each kind, field extremes, the u = 0 / 1 / 2 corners
        add_chunk(KIND_SWAP,   '1, '0, '0, 8'h00, 1'b0);
        add_chunk(KIND_SWAP,   random_word(), random_word(), '1, 8'hFF, 1'b1);
        add_chunk(KIND_MAC,    random_word(), random_word(), '0, 8'h00, 1'b0); // no change
        add_chunk(KIND_MAC,    random_word(), random_word(), '0, 8'h01, 1'b1); // plain xor
        add_chunk(KIND_MAC,    random_word(), '1, '1, 8'hFF, 1'b0);
        add_chunk(KIND_MAC,    '0, random_word(), '0, 8'h02, 1'b1);
        add_chunk(KIND_ADD,    '1, '1, '0, 8'h00, 1'b0);
        add_chunk(KIND_ADD,    random_word(), random_word(), '1, 8'hFF, 1'b1);
        add_chunk(KIND_SCALE,  random_word(), random_word(), '0, 8'h00, 1'b0); // unchanged
        add_chunk(KIND_SCALE,  random_word(), random_word(), '0, 8'h01, 1'b1); // unchanged
        add_chunk(KIND_SCALE,  '1, '0, '1, 8'h02, 1'b0);                      // smallest real scale
        add_chunk(KIND_SCALE,  '1, random_word(), '0, 8'hFF, 1'b1);
        add_chunk(KIND_BITACC, random_word(), random_word(), '0, 8'hFF, 1'b0); // no bits set
        add_chunk(KIND_BITACC, random_word(), random_word(), '1, 8'hFF, 1'b1); // every lane
        add_chunk(KIND_BITACC, '0, '1, 8'hA5, 8'h5A, 1'b0);
        add_chunk(KIND_BITACC, '1, '0, 8'h5A, 8'h00, 1'b1);
        // Unused kind codes pass both words through
        for (int c = KIND_BITACC + 1; c < (1 << KIND_W); c++) begin
            add_chunk(KIND_W'(c), random_word(), random_word(), '1, 8'hFF, c[0]);
        end

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(99) < 4) begin
                k = KIND_W'($urandom_range(KIND_BITACC + 1, (1 << KIND_W) - 1));
            end else begin
                k = KIND_W'($urandom_range(KIND_SWAP, KIND_BITACC));
            end
            add_chunk(k, random_word(), random_word(), OCTETS'($urandom_range(255)),
                      random_mult(), 1'($urandom_range(1)));
        end
        total = chunk_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // All words offered and taken
        while (chunk_q.size() != 0 || s_valid) @(negedge aclk);

        drain = 0;
        while (row_result_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain++;
        end
        if (row_result_q.size() != 0) begin
            $error("%0d predicted result words never arrived", row_result_q.size());
            errors++;
        end
        // Wait on a little to catch stray result words
        repeat (4) @(negedge aclk);

        $display("Ran %0d of %0d words: swap %0d, mac %0d, add %0d, scale %0d, bitacc %0d,",
                 words_in, total, kind_count[KIND_SWAP], kind_count[KIND_MAC],
                 kind_count[KIND_ADD], kind_count[KIND_SCALE], kind_count[KIND_BITACC]);
        $display("unused %0d; %0d result words checked under random stalls and a %0d-cycle hold",
                 kind_count[5] + kind_count[6] + kind_count[7], words_out, HOLD_CYCLES);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
